>>> rtl/core/pcc_pkg.sv
// Shared types, codes and constants for the plant condition classifier.
// No dependencies; imported by every module of the block.
package pcc_pkg;

	// Block defaults for the top level parameters
	localparam int unsigned NIGHT_RUN_LENGTH_DEF = 3;
	localparam int unsigned OFFLINE_AGE_DEF      = 5400;

	// Condition codes
	typedef enum logic [3:0] {
		C_UNKNOWN  = 4'd0,
		C_OFFLINE  = 4'd1,
		C_SLEEPING = 4'd2,
		C_HAPPY    = 4'd3,
		C_THIRSTY  = 4'd4,
		C_DROWNING = 4'd5,
		C_COLD     = 4'd6,
		C_HOT      = 4'd7,
		C_SCORCHED = 4'd8,
		C_DARK     = 4'd9,
		C_DRYAIR   = 4'd10
	} cond_t;

	// Severity codes
	typedef enum logic [1:0] {
		SEV_OK     = 2'd0,
		SEV_WATCH  = 2'd1,
		SEV_URGENT = 2'd2
	} sev_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SOIL_LOW    = 3'd0,
		REG_SOIL_HIGH   = 3'd1,
		REG_TEMP_LOW    = 3'd2,
		REG_TEMP_HIGH   = 3'd3,
		REG_LIGHT_LOW   = 3'd4,
		REG_LIGHT_HIGH  = 3'd5,
		REG_HUM_LOW     = 3'd6,
		REG_NIGHT_LEVEL = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 18;

	// Hysteresis margins and urgency offsets
	localparam logic        [7:0]  MARGIN_SOIL = 8'd4;
	localparam logic        [6:0]  SOIL_WET_MIN = 7'd4;
	localparam logic signed [12:0] MARGIN_TEMP = 13'sd15;
	localparam logic        [7:0]  MARGIN_HUM  = 8'd5;
	localparam logic        [7:0]  URGENT_DRY  = 8'd8;
	localparam logic        [7:0]  URGENT_WET  = 8'd12;
	localparam logic signed [12:0] URGENT_TEMP = 13'sd50;
	localparam logic        [15:0] DARK_CNT_MAX = 16'hFFFF;

	// floor(x/5) for 18-bit x: x * ceil(2^20/5) >> 20 is exact below 2^18
	localparam logic [17:0] DIV5_RECIP = 18'd209716;

	// Reset values of the configuration registers
	localparam logic [6:0]  SOIL_LOW_RST    = 7'd30;
	localparam logic [6:0]  SOIL_HIGH_RST   = 7'd80;
	localparam logic [11:0] TEMP_LOW_RST    = 12'd100;
	localparam logic [11:0] TEMP_HIGH_RST   = 12'd300;
	localparam logic [17:0] LIGHT_LOW_RST   = 18'd1000;
	localparam logic [17:0] LIGHT_HIGH_RST  = 18'd50000;
	localparam logic [6:0]  HUM_LOW_RST     = 7'd40;
	localparam logic [17:0] NIGHT_LEVEL_RST = 18'd10;

	// Configuration as seen by the classifier; fifth parts precomputed on write
	typedef struct packed {
		logic [6:0]  soil_low;
		logic [6:0]  soil_high;
		logic [11:0] temp_low;
		logic [11:0] temp_high;
		logic [17:0] light_low;
		logic [15:0] light_low_fifth;
		logic [17:0] light_high;
		logic [15:0] light_high_fifth;
		logic [6:0]  humidity_low;
		logic [17:0] night_light_level;
	} cfg_t;

	// One telemetry sample
	typedef struct packed {
		logic        sample_valid;
		logic [15:0] sample_age;
		logic [6:0]  soil_moisture;
		logic [11:0] temperature;
		logic [17:0] light_level;
		logic [6:0]  air_humidity;
	} sample_t;

	// One classification result
	typedef struct packed {
		cond_t cond;
		sev_t  sev;
	} result_t;

	function automatic logic [15:0] div5(input logic [17:0] x);
		logic [35:0] prod;
		prod = {18'd0, x} * {18'd0, DIV5_RECIP};
		return prod[35:20];
	endfunction

endpackage

>>> rtl/core/pcc_cfg.sv
// Configuration register file of the plant condition classifier.
// Depends on pcc_pkg (cfg_t, register indexes, reset values, div5).
module pcc_cfg
	import pcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic [15:0] wdata_fifth;

	// fifth of the written value, stored beside the light limits
	assign wdata_fifth = div5(cfg_wdata);

	// register writes; bits above a register's width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soil_low          <= SOIL_LOW_RST;
			cfg_q.soil_high         <= SOIL_HIGH_RST;
			cfg_q.temp_low          <= TEMP_LOW_RST;
			cfg_q.temp_high         <= TEMP_HIGH_RST;
			cfg_q.light_low         <= LIGHT_LOW_RST;
			cfg_q.light_low_fifth   <= div5(LIGHT_LOW_RST);
			cfg_q.light_high        <= LIGHT_HIGH_RST;
			cfg_q.light_high_fifth  <= div5(LIGHT_HIGH_RST);
			cfg_q.humidity_low      <= HUM_LOW_RST;
			cfg_q.night_light_level <= NIGHT_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				REG_SOIL_LOW:    cfg_q.soil_low  <= cfg_wdata[6:0];
				REG_SOIL_HIGH:   cfg_q.soil_high <= cfg_wdata[6:0];
				REG_TEMP_LOW:    cfg_q.temp_low  <= cfg_wdata[11:0];
				REG_TEMP_HIGH:   cfg_q.temp_high <= cfg_wdata[11:0];
				REG_LIGHT_LOW: begin
					cfg_q.light_low       <= cfg_wdata;
					cfg_q.light_low_fifth <= wdata_fifth;
				end
				REG_LIGHT_HIGH: begin
					cfg_q.light_high       <= cfg_wdata;
					cfg_q.light_high_fifth <= wdata_fifth;
				end
				REG_HUM_LOW:     cfg_q.humidity_low      <= cfg_wdata[6:0];
				REG_NIGHT_LEVEL: cfg_q.night_light_level <= cfg_wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/pcc_eval.sv
// Single-pass classification of one sample against limits and previous state.
// Depends on pcc_pkg (cfg_t, sample_t, result_t, codes, margins).
module pcc_eval
	import pcc_pkg::*;
#(
	parameter int unsigned NIGHT_RUN_LENGTH = NIGHT_RUN_LENGTH_DEF,
	parameter int unsigned OFFLINE_AGE      = OFFLINE_AGE_DEF
) (
	input  cfg_t        cfg,
	input  sample_t     smp,
	input  cond_t       prev_cond,
	input  logic [15:0] dark_cnt,
	output logic [15:0] dark_cnt_next,
	output result_t     res
);

	logic               offline;
	logic               night;
	logic [7:0]         soil_x;
	logic [7:0]         dry_lim;
	logic [6:0]         wet_lim;
	logic signed [12:0] temp_x;
	logic signed [12:0] t_lo_x;
	logic signed [12:0] t_hi_x;
	logic signed [12:0] cold_lim;
	logic signed [12:0] hot_lim;
	logic [18:0]        dark_lim;
	logic [17:0]        bright_lim;
	logic [7:0]         hum_lim;

	assign offline = !smp.sample_valid || (smp.sample_age > 16'(OFFLINE_AGE));

	// dark run counter, saturating; offline samples leave it alone
	always_comb begin
		dark_cnt_next = dark_cnt;
		if (!offline) begin
			if (smp.light_level < cfg.night_light_level) begin
				if (dark_cnt != DARK_CNT_MAX)
					dark_cnt_next = dark_cnt + 16'd1;
			end else begin
				dark_cnt_next = '0;
			end
		end
	end

	assign night = dark_cnt_next >= 16'(NIGHT_RUN_LENGTH);

	// limits, widened while the matching condition persists
	assign soil_x  = {1'b0, smp.soil_moisture};
	assign dry_lim = {1'b0, cfg.soil_low} + ((prev_cond == C_THIRSTY) ? MARGIN_SOIL : 8'd0);
	assign wet_lim = cfg.soil_high -
		(((prev_cond == C_DROWNING) && (cfg.soil_high > SOIL_WET_MIN)) ? SOIL_WET_MIN : 7'd0);

	assign temp_x   = {smp.temperature[11], smp.temperature};
	assign t_lo_x   = {cfg.temp_low[11], cfg.temp_low};
	assign t_hi_x   = {cfg.temp_high[11], cfg.temp_high};
	assign cold_lim = t_lo_x + ((prev_cond == C_COLD) ? MARGIN_TEMP : 13'sd0);
	assign hot_lim  = t_hi_x - ((prev_cond == C_HOT) ? MARGIN_TEMP : 13'sd0);

	assign dark_lim   = {1'b0, cfg.light_low} +
		((prev_cond == C_DARK) ? {3'd0, cfg.light_low_fifth} : 19'd0);
	assign bright_lim = cfg.light_high -
		((prev_cond == C_SCORCHED) ? {2'd0, cfg.light_high_fifth} : 18'd0);

	assign hum_lim = {1'b0, cfg.humidity_low} + ((prev_cond == C_DRYAIR) ? MARGIN_HUM : 8'd0);

	// checks in priority order; urgency uses the plain limits
	always_comb begin
		priority if (offline) begin
			res = '{cond: C_OFFLINE, sev: SEV_WATCH};
		end else if (soil_x < dry_lim) begin
			res.cond = C_THIRSTY;
			res.sev  = ((soil_x + URGENT_DRY) < {1'b0, cfg.soil_low}) ? SEV_URGENT : SEV_WATCH;
		end else if (smp.soil_moisture > wet_lim) begin
			res.cond = C_DROWNING;
			res.sev  = (soil_x > ({1'b0, cfg.soil_high} + URGENT_WET)) ? SEV_URGENT : SEV_WATCH;
		end else if (temp_x < cold_lim) begin
			res.cond = C_COLD;
			res.sev  = (temp_x < (t_lo_x - URGENT_TEMP)) ? SEV_URGENT : SEV_WATCH;
		end else if (temp_x > hot_lim) begin
			res.cond = C_HOT;
			res.sev  = (temp_x > (t_hi_x + URGENT_TEMP)) ? SEV_URGENT : SEV_WATCH;
		end else if (night) begin
			res = '{cond: C_SLEEPING, sev: SEV_OK};
		end else if (smp.light_level > bright_lim) begin
			res = '{cond: C_SCORCHED, sev: SEV_WATCH};
		end else if ({1'b0, smp.light_level} < dark_lim) begin
			res = '{cond: C_DARK, sev: SEV_WATCH};
		end else if ({1'b0, smp.air_humidity} < hum_lim) begin
			res = '{cond: C_DRYAIR, sev: SEV_WATCH};
		end else begin
			res = '{cond: C_HAPPY, sev: SEV_OK};
		end
	end

endmodule

>>> rtl/core/plant_condition_classifier_top.sv
// Top level of the plant condition classifier: input stage, state, output register.
// Depends on pcc_pkg, pcc_cfg and pcc_eval.
//
// Usage:
//  - Input channel in_valid/in_ready carries one telemetry sample per transfer.
//  - Output channel out_valid/out_ready carries one condition and severity per
//    sample, in order, exactly one result per input transfer.
//  - Configuration: cfg_we writes cfg_wdata into register cfg_addr;
//    write only while no sample is in flight.
//  - Path: a sample transferred into the input stage is classified there and
//    lands in the output register once that is free; out_valid is high after it.
//  - Throughput: one sample per cycle. The input stage and the output register
//    each hold one item; the classification is a single compare chain between
//    them, and previous condition and dark count update as an item moves on.
//  - Receiver stall: the output register holds its result, the input stage
//    keeps one more sample, then in_ready drops until out_ready returns.
//  - Reset (arst_n low): both stages empty, previous condition unknown, dark
//    count zero, registers back to their default limits.
module plant_condition_classifier_top
	import pcc_pkg::*;
#(
	parameter int unsigned NIGHT_RUN_LENGTH = NIGHT_RUN_LENGTH_DEF,
	parameter int unsigned OFFLINE_AGE      = OFFLINE_AGE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// sample channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  sample_valid,
	input  logic [15:0]           sample_age,
	input  logic [6:0]            soil_moisture,
	input  logic signed [11:0]    temperature,
	input  logic [17:0]           light_level,
	input  logic [6:0]            air_humidity,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            condition,
	output logic [1:0]            severity
);

	cfg_t        cfg;
	sample_t     smp_s1;
	logic        vld_s1;
	logic        adv_s1;
	logic        out_free;
	logic        out_vld_q;
	result_t     res_q;
	result_t     res_next;
	cond_t       prev_cond_q;
	logic [15:0] dark_cnt_q;
	logic [15:0] dark_cnt_next;

	pcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcc_eval #(
		.NIGHT_RUN_LENGTH (NIGHT_RUN_LENGTH),
		.OFFLINE_AGE      (OFFLINE_AGE)
	) u_eval (
		.cfg           (cfg),
		.smp           (smp_s1),
		.prev_cond     (prev_cond_q),
		.dark_cnt      (dark_cnt_q),
		.dark_cnt_next (dark_cnt_next),
		.res           (res_next)
	);

	// handshake: the output register frees when empty or taken this cycle
	assign out_free = !out_vld_q || out_ready;
	assign adv_s1   = vld_s1 && out_free;
	assign in_ready = !vld_s1 || out_free;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			smp_s1 <= '{sample_valid:  sample_valid,
			            sample_age:    sample_age,
			            soil_moisture: soil_moisture,
			            temperature:   temperature,
			            light_level:   light_level,
			            air_humidity:  air_humidity};
	end

	// classifier state advances with each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cond_q <= C_UNKNOWN;
			dark_cnt_q  <= '0;
		end else if (adv_s1) begin
			prev_cond_q <= res_next.cond;
			dark_cnt_q  <= dark_cnt_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_free)
			out_vld_q <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_q <= res_next;
	end

	assign out_valid = out_vld_q;
	assign condition = res_q.cond;
	assign severity  = res_q.sev;

	// previous condition always follows the result just produced
	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (prev_cond_q == res_q.cond))
		else $error("previous condition differs from last result");

	// offline samples do not touch the dark counter
	a_offline_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_next.cond == C_OFFLINE) |=> $stable(dark_cnt_q))
		else $error("dark count changed on offline sample");

	// offline always reports watch
	a_offline_sev: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_q.cond == C_OFFLINE) |-> (res_q.sev == SEV_WATCH))
		else $error("offline result with wrong severity");

	// sleeping is only reported after a long enough dark run
	a_sleep_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_q.cond == C_SLEEPING) |-> (dark_cnt_q >= 16'(NIGHT_RUN_LENGTH)))
		else $error("sleeping without dark run");

	// a stalled result is never overwritten by the input stage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |-> !adv_s1)
		else $error("output register overwritten while stalled");

endmodule

>>> dv/tb_plant_condition_classifier_top.sv
// Self-checking testbench for plant_condition_classifier_top: a directed script, then
// random samples over several limit settings, every result checked against a predictor
// or a typed expectation. Depends on pcc_pkg and the classifier RTL only.
`timescale 1ns / 100ps

module tb_plant_condition_classifier_top;
	import pcc_pkg::*;

	localparam int OFFLINE_AGE     = OFFLINE_AGE_DEF;
	localparam int NIGHT_RUN       = NIGHT_RUN_LENGTH_DEF;
	localparam int SOIL_BAND       = 4;
	localparam int TEMP_BAND       = 15;
	localparam int HUM_BAND        = 5;
	localparam int LIGHT_BAND_DIV  = 5;
	localparam int DRY_URGENT      = 8;
	localparam int WET_URGENT      = 12;
	localparam int TEMP_URGENT     = 50;
	localparam int N_SCRIPT        = 30;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int STEADY_PHASE    = 6;
	localparam int CYCLE_LIMIT     = 200000;

	typedef enum {LIMITS_KEEP, LIMITS_RANDOM, LIMITS_FLOOR, LIMITS_CEIL, LIMITS_WILD,
		LIMITS_TIGHT} limit_set_t;

	typedef struct {
		sample_t s;
		logic    typed;
		result_t r;
	} script_row_t;

	localparam result_t NO_RESULT = '{C_UNKNOWN, SEV_OK};

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [2:0]            cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic                  sample_valid  = 1'b0;
	logic [15:0]           sample_age    = '0;
	logic [6:0]            soil_moisture = '0;
	logic signed [11:0]    temperature   = '0;
	logic [17:0]           light_level   = '0;
	logic [6:0]            air_humidity  = '0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic [3:0]            condition;
	logic [1:0]            severity;

	// Predictor copy of the limits and of the classifier state
	logic [6:0]  lim_soil_low    = SOIL_LOW_RST;
	logic [6:0]  lim_soil_high   = SOIL_HIGH_RST;
	logic [11:0] lim_temp_low    = TEMP_LOW_RST;
	logic [11:0] lim_temp_high   = TEMP_HIGH_RST;
	logic [17:0] lim_light_low   = LIGHT_LOW_RST;
	logic [17:0] lim_light_high  = LIGHT_HIGH_RST;
	logic [6:0]  lim_hum_low     = HUM_LOW_RST;
	logic [17:0] lim_night_level = NIGHT_LEVEL_RST;
	cond_t       last_cond       = C_UNKNOWN;
	logic [15:0] dark_run        = '0;

	result_t pending_results [$];
	result_t want;
	int      mismatches  = 0;
	int      cycle_count = 0;
	int      dark_spell  = 0;
	logic    steady      = 1'b0;

	limit_set_t plan [N_PHASES] = '{LIMITS_KEEP, LIMITS_RANDOM, LIMITS_FLOOR, LIMITS_CEIL,
		LIMITS_WILD, LIMITS_TIGHT, LIMITS_RANDOM, LIMITS_RANDOM};

	// Directed script, reset limits: offline, every condition at its extremes,
	// hysteresis entry and exit at the widened limit, night run build-up
	script_row_t script [N_SCRIPT] = '{
		'{'{1'b0, 16'd100,  7'd50,  12'd200,  18'd5000,   7'd60},  1'b1, '{C_OFFLINE, SEV_WATCH}},
		'{'{1'b1, 16'd5401, 7'd50,  12'd200,  18'd5000,   7'd60},  1'b1, '{C_OFFLINE, SEV_WATCH}},
		'{'{1'b1, 16'hFFFF, 7'd0,   12'h800,  18'd0,      7'd0},   1'b1, '{C_OFFLINE, SEV_WATCH}},
		'{'{1'b1, 16'd5400, 7'd50,  12'd200,  18'd5000,   7'd60},  1'b1, '{C_HAPPY, SEV_OK}},
		'{'{1'b1, 16'd0,    7'd0,   12'd200,  18'd5000,   7'd60},  1'b1, '{C_THIRSTY, SEV_URGENT}},
		'{'{1'b1, 16'd100,  7'd31,  12'd200,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd34,  12'd200,  18'd5000,   7'd127}, 1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd127, 12'd200,  18'd5000,   7'd60},  1'b1, '{C_DROWNING, SEV_URGENT}},
		'{'{1'b1, 16'd100,  7'd77,  12'd200,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd76,  12'd200,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'h800,  18'd5000,   7'd60},  1'b1, '{C_COLD, SEV_URGENT}},
		'{'{1'b1, 16'd100,  7'd50,  12'd110,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd115,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'h7FF,  18'd5000,   7'd60},  1'b1, '{C_HOT, SEV_URGENT}},
		'{'{1'b1, 16'd100,  7'd50,  12'd290,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd285,  18'd5000,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'h3FFFF,  7'd60},  1'b1, '{C_SCORCHED, SEV_WATCH}},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd45000,  7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd40000,  7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd999,    7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd1100,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd1200,   7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd5000,   7'd0},   1'b1, '{C_DRYAIR, SEV_WATCH}},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd5000,   7'd44},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd5000,   7'd45},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd0,      7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd0,      7'd60},  1'b0, NO_RESULT},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd0,      7'd60},  1'b0, NO_RESULT},
		'{'{1'b0, 16'd100,  7'd50,  12'd200,  18'd0,      7'd60},  1'b1, '{C_OFFLINE, SEV_WATCH}},
		'{'{1'b1, 16'd100,  7'd50,  12'd200,  18'd0,      7'd60},  1'b0, NO_RESULT}
	};

	plant_condition_classifier_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_valid (sample_valid),
		.sample_age   (sample_age),
		.soil_moisture(soil_moisture),
		.temperature  (temperature),
		.light_level  (light_level),
		.air_humidity (air_humidity),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.condition    (condition),
		.severity     (severity)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Register write as the block sees it: bits above the register width drop
	function automatic void apply_limit(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_SOIL_LOW:    lim_soil_low    = d[6:0];
			REG_SOIL_HIGH:   lim_soil_high   = d[6:0];
			REG_TEMP_LOW:    lim_temp_low    = d[11:0];
			REG_TEMP_HIGH:   lim_temp_high   = d[11:0];
			REG_LIGHT_LOW:   lim_light_low   = d[17:0];
			REG_LIGHT_HIGH:  lim_light_high  = d[17:0];
			REG_HUM_LOW:     lim_hum_low     = d[6:0];
			REG_NIGHT_LEVEL: lim_night_level = d[17:0];
			default: ;
		endcase
	endfunction

	// Predicts the condition and severity of one sample and advances the state
	function automatic result_t classify(input sample_t s);
		int          soil, tmp, hum, s_lo, s_hi, dry, wet, t_lo, t_hi, cold_lim, hot_lim, h_lim;
		int unsigned lux, l_lo, l_hi;
		result_t     r;
		cond_t       last;
		last = last_cond;
		soil = s.soil_moisture;
		tmp  = $signed(s.temperature);
		lux  = s.light_level;
		hum  = s.air_humidity;
		s_lo = lim_soil_low;
		s_hi = lim_soil_high;
		t_lo = $signed(lim_temp_low);
		t_hi = $signed(lim_temp_high);
		l_lo = lim_light_low;
		l_hi = lim_light_high;
		h_lim = lim_hum_low;
		if (!s.sample_valid || s.sample_age > OFFLINE_AGE) begin
			// dark run untouched while offline
			r.cond = C_OFFLINE;
			r.sev  = SEV_WATCH;
		end else begin
			if (lux < lim_night_level) begin
				if (dark_run != 16'hFFFF)
					dark_run = dark_run + 16'd1;
			end else begin
				dark_run = '0;
			end
			dry = s_lo;
			wet = s_hi;
			if (last == C_THIRSTY)
				dry = dry + SOIL_BAND;
			if (last == C_DROWNING && wet > SOIL_BAND)
				wet = wet - SOIL_BAND;
			cold_lim = (last == C_COLD) ? t_lo + TEMP_BAND : t_lo;
			hot_lim  = (last == C_HOT) ? t_hi - TEMP_BAND : t_hi;
			if (last == C_DARK)
				l_lo = l_lo + l_lo / LIGHT_BAND_DIV;
			if (last == C_SCORCHED)
				l_hi = l_hi - l_hi / LIGHT_BAND_DIV;
			if (last == C_DRYAIR)
				h_lim = h_lim + HUM_BAND;
			// priority chain; urgency against the plain limits
			r.sev = SEV_WATCH;
			if (soil < dry) begin
				r.cond = C_THIRSTY;
				if (soil + DRY_URGENT < s_lo)
					r.sev = SEV_URGENT;
			end else if (soil > wet) begin
				r.cond = C_DROWNING;
				if (soil > s_hi + WET_URGENT)
					r.sev = SEV_URGENT;
			end else if (tmp < cold_lim) begin
				r.cond = C_COLD;
				if (tmp < t_lo - TEMP_URGENT)
					r.sev = SEV_URGENT;
			end else if (tmp > hot_lim) begin
				r.cond = C_HOT;
				if (tmp > t_hi + TEMP_URGENT)
					r.sev = SEV_URGENT;
			end else if (dark_run >= NIGHT_RUN) begin
				r.cond = C_SLEEPING;
				r.sev  = SEV_OK;
			end else if (lux > l_hi) begin
				r.cond = C_SCORCHED;
			end else if (lux < l_lo) begin
				r.cond = C_DARK;
			end else if (hum < h_lim) begin
				r.cond = C_DRYAIR;
			end else begin
				r.cond = C_HAPPY;
				r.sev  = SEV_OK;
			end
		end
		last_cond = r.cond;
		return r;
	endfunction

	function automatic int near(input int c, input int span);
		return c - span + int'($urandom_range(2 * span));
	endfunction

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Random sample aimed mostly at the current limits, with dark spells for night
	function automatic sample_t make_sample();
		sample_t     s;
		int          soil, tmp, hum, s_lo, s_hi, t_lo, t_hi, pick;
		int          l_lo, l_hi;
		int unsigned lux;
		s_lo = lim_soil_low;
		s_hi = lim_soil_high;
		t_lo = $signed(lim_temp_low);
		t_hi = $signed(lim_temp_high);
		l_lo = lim_light_low;
		l_hi = lim_light_high;
		pick = $urandom_range(99);
		s.sample_valid = 1'b1;
		s.sample_age   = 16'($urandom_range(OFFLINE_AGE));
		if (pick < 5) begin
			s.sample_valid = 1'b0;
			s.sample_age   = 16'($urandom);
		end else if (pick < 10) begin
			s.sample_age = 16'($urandom_range(16'hFFFF, OFFLINE_AGE + 1));
		end
		case ($urandom_range(5))
			0:       soil = $urandom_range(127);
			1:       soil = near(s_lo, 12);
			2:       soil = near(s_hi, 14);
			default: soil = near((s_lo + s_hi) / 2, 6);
		endcase
		s.soil_moisture = 7'(clip(soil, 0, 127));
		case ($urandom_range(5))
			0:       tmp = int'($urandom_range(4095)) - 2048;
			1:       tmp = near(t_lo, 80);
			2:       tmp = near(t_hi, 80);
			default: tmp = near((t_lo + t_hi) / 2, 40);
		endcase
		s.temperature = 12'(clip(tmp, -2048, 2047));
		if (dark_spell != 0) begin
			dark_spell = dark_spell - 1;
			lux = (lim_night_level == 0) ? 0 : $urandom_range(lim_night_level - 1);
		end else begin
			case ($urandom_range(9))
				0: lux = $urandom_range(18'h3FFFF);
				1: begin
					dark_spell = $urandom_range(6, 2);
					lux = 0;
				end
				2, 3:    lux = clip(near(l_lo, l_lo / 4 + 8), 0, 18'h3FFFF);
				4, 5:    lux = clip(near(l_hi, l_hi / 4 + 8), 0, 18'h3FFFF);
				default: lux = clip(near((l_lo + l_hi) / 2, 50), 0, 18'h3FFFF);
			endcase
		end
		s.light_level = 18'(lux);
		case ($urandom_range(3))
			0:       hum = $urandom_range(127);
			1:       hum = near(lim_hum_low, 8);
			default: hum = lim_hum_low + int'($urandom_range(60, 5));
		endcase
		s.air_humidity = 7'(clip(hum, 0, 127));
		return s;
	endfunction

	// One sample transfer; a typed expectation overrides the predictor's
	task automatic send_sample(input sample_t s, input logic typed, input result_t r);
		result_t pred;
		while (!steady && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		sample_valid  <= s.sample_valid;
		sample_age    <= s.sample_age;
		soil_moisture <= s.soil_moisture;
		temperature   <= s.temperature;
		light_level   <= s.light_level;
		air_humidity  <= s.air_humidity;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = classify(s);
		pending_results.push_back(typed ? r : pred);
	endtask

	// Wait for the block to go idle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all eight limit registers, one per cycle
	task automatic load_limits(input limit_set_t kind);
		logic [CFG_DATA_W-1:0] val [8];
		cfg_idx_t              idx;
		int                    t;
		for (int i = 0; i < 8; i++)
			val[i] = CFG_DATA_W'($urandom);
		case (kind)
			LIMITS_FLOOR: begin
				val = '{default: '0};
				val[REG_TEMP_LOW]  = 18'h800;
				val[REG_TEMP_HIGH] = 18'h800;
			end
			LIMITS_CEIL: begin
				val = '{default: '1};
				val[REG_TEMP_LOW]  = 18'h7FF;
				val[REG_TEMP_HIGH] = 18'h7FF;
			end
			LIMITS_RANDOM: begin
				val[REG_SOIL_LOW]    = {11'($urandom), 7'($urandom_range(60))};
				val[REG_SOIL_HIGH]   = {11'($urandom), 7'($urandom_range(100, 40))};
				val[REG_TEMP_LOW]    = {6'($urandom), 12'($urandom_range(1600) - 1000)};
				val[REG_TEMP_HIGH]   = {6'($urandom), 12'($urandom_range(1500))};
				val[REG_LIGHT_LOW]   = 18'($urandom_range(20000));
				val[REG_LIGHT_HIGH]  = 18'($urandom_range(18'h3FFFF, 5000));
				val[REG_HUM_LOW]     = {11'($urandom), 7'($urandom_range(100))};
				val[REG_NIGHT_LEVEL] = 18'($urandom_range(3000));
			end
			LIMITS_TIGHT: begin
				// soil high straddles the hysteresis margin
				t = int'($urandom_range(60)) - 30;
				val[REG_SOIL_LOW]    = 18'($urandom_range(8));
				val[REG_SOIL_HIGH]   = 18'($urandom_range(6, 2));
				val[REG_TEMP_LOW]    = 18'(12'(t));
				val[REG_TEMP_HIGH]   = 18'(12'(t + int'($urandom_range(20))));
				val[REG_LIGHT_LOW]   = 18'($urandom_range(12));
				val[REG_LIGHT_HIGH]  = 18'($urandom_range(12));
				val[REG_HUM_LOW]     = 18'($urandom_range(8));
				val[REG_NIGHT_LEVEL] = 18'($urandom_range(6));
			end
			default: ;
		endcase
		for (int i = 0; i < 8; i++) begin
			idx = cfg_idx_t'(i);
			cfg_we    <= 1'b1;
			cfg_addr  <= idx;
			cfg_wdata <= val[i];
			@(posedge clk);
			apply_limit(idx, val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Receiver stalls at random except during the steady phase
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 24);

	// Result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got condition %0d severity %0d",
					$time, condition, severity);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (condition !== want.cond) begin
					$display("%0t: condition expected %0d got %0d", $time, want.cond, condition);
					mismatches++;
				end
				if (severity !== want.sev) begin
					$display("%0t: severity expected %0d got %0d", $time, want.sev, severity);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_SCRIPT; i++)
			send_sample(script[i].s, script[i].typed, script[i].r);
		for (int p = 0; p < N_PHASES; p++) begin
			if (plan[p] != LIMITS_KEEP) begin
				drain();
				load_limits(plan[p]);
			end
			steady <= (p == STEADY_PHASE);
			repeat (ITEMS_PER_PHASE)
				send_sample(make_sample(), 1'b0, NO_RESULT);
		end
		drain();
		// leftovers mean results never came out
		mismatches = mismatches + pending_results.size();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_cfg.sv
rtl/core/pcc_eval.sv
rtl/core/plant_condition_classifier_top.sv
dv/tb_plant_condition_classifier_top.sv
